@@ rtl/core/tbst_pkg.sv @@
package tbst_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;

  // fixed port field widths
  localparam int PORT_KEY_W = 32;
  localparam int COUNT_W    = 5;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_GET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_FRONT,
    CELL_FROM_BACK,
    CELL_FROM_HEAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      occupied;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

endpackage

@@ rtl/core/tbst_if.sv @@
interface tbst_in_if import tbst_pkg::*;;
  logic                  valid;
  logic                  ready;
  op_t                   op;
  logic [PORT_KEY_W-1:0] key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

interface tbst_out_if import tbst_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  success;
  logic [PORT_KEY_W-1:0] value;
  logic [COUNT_W-1:0]    count;
  logic                  last;

  modport source (output valid, success, value, count, last, input ready);
  modport sink   (input valid, success, value, count, last, output ready);
endinterface

@@ rtl/core/tbst_cell.sv @@
module tbst_cell import tbst_pkg::*; #(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [KEY_WIDTH-1:0] front_key_i,
  input  logic [KEY_WIDTH-1:0] back_key_i,
  input  logic [KEY_WIDTH-1:0] head_key_i,
  input  logic [KEY_WIDTH-1:0] match_key_i,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 hit_o
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;

  always_comb begin
    case (ctl.cmd)
      CELL_FROM_FRONT: key_nxt = front_key_i;
      CELL_FROM_BACK:  key_nxt = back_key_i;
      CELL_FROM_HEAD:  key_nxt = head_key_i;
      default:         key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;
  assign hit_o = ctl.occupied && (key_r == match_key_i);

endmodule

@@ rtl/core/transpose_back_set_table.sv @@
// Add, get and delete are accepted in ST_IDLE; ST_EXEC waits until the result
// side is free, then registers their single result, and a new item is taken only back in ST_IDLE.
// Read all passes ST_EXEC as a decode state, then ST_READ sends one entry per
// cycle rotated out of the front cell, while the result side does not stall.
// Reset (rst_n low, synchronous) clears the count, the control state and the
// output valid; cell keys are not reset and are read only below the count.
module transpose_back_set_table import tbst_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  tbst_in_if.sink         in_ch,
  tbst_out_if.source      out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] ALL_ONES = '1;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  op_t                  op_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_success_r, out_success_nxt;
  logic [PORT_KEY_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  occ;
  cell_ctl_t            ctl [CAPACITY];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = CW'(i) < count_r;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] front_key;
      logic [KEY_WIDTH-1:0] back_key;
      if (g == 0) begin : g_head
        assign front_key = key_r;
      end else begin : g_body
        assign front_key = cell_key[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign back_key = cell_key[g];
      end else begin : g_inner
        assign back_key = cell_key[g+1];
      end
      tbst_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
        .clk         (clk),
        .ctl         (ctl[g]),
        .front_key_i (front_key),
        .back_key_i  (back_key),
        .head_key_i  (cell_key[0]),
        .match_key_i (key_r),
        .key_o       (cell_key[g]),
        .hit_o       (hit[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    out_success_r <= out_success_nxt;
    out_value_r   <= out_value_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    logic                out_free;
    logic                any_hit;
    logic                ok;
    logic [CAPACITY-1:0] hit_sh;
    logic [CAPACITY-1:0] occ_sh;
    logic [CAPACITY-1:0] after_hit;
    logic                read_last;

    out_free  = !out_valid_r || out_ch.ready;
    any_hit   = |hit;
    hit_sh    = hit << 1;
    occ_sh    = occ >> 1;
    read_last = (idx_r + CW'(1)) == count_r;
    ok        = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      after_hit[i] = |(hit & (ALL_ONES >> (CAPACITY - 1 - i)));
    end

    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_success_nxt = out_success_r;
    out_value_nxt   = out_value_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].cmd      = CELL_HOLD;
      ctl[i].occupied = occ[i];
    end
    in_ch.ready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          key_nxt   = KEY_WIDTH'(in_ch.key);
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          unique case (op_r)
            OP_ADD: begin
              ok = !any_hit && (count_r < CW'(CAPACITY));
              if (ok) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  ctl[i].cmd = CELL_FROM_FRONT;
                end
                count_nxt = count_r + CW'(1);
              end
            end
            OP_GET: begin
              ok = any_hit;
              if (ok) begin
                out_value_nxt = PORT_KEY_W'(key_r);
              end
              // swap the hit entry with the one behind it
              for (int i = 0; i < CAPACITY; i++) begin
                if (hit[i] && occ_sh[i]) begin
                  ctl[i].cmd = CELL_FROM_BACK;
                end else if (hit_sh[i] && occ[i]) begin
                  ctl[i].cmd = CELL_FROM_FRONT;
                end
              end
            end
            OP_DEL: begin
              ok = any_hit;
              if (ok) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (after_hit[i]) begin
                    ctl[i].cmd = CELL_FROM_BACK;
                  end
                end
                count_nxt = count_r - CW'(1);
              end
            end
            OP_READ: begin
              if (count_r != '0) begin
                out_valid_nxt = out_valid_r && !out_ch.ready;
                idx_nxt       = '0;
                state_nxt     = ST_READ;
              end
            end
            default: ;
          endcase
          out_success_nxt = ok;
          out_count_nxt   = COUNT_W'(count_nxt);
        end
      end

      ST_READ: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b1;
          out_value_nxt   = PORT_KEY_W'(cell_key[0]);
          out_count_nxt   = COUNT_W'(count_r);
          out_last_nxt    = read_last;
          // rotate the held entries one place toward the front
          for (int i = 0; i < CAPACITY; i++) begin
            if (occ_sh[i]) begin
              ctl[i].cmd = CELL_FROM_BACK;
            end else if (occ[i]) begin
              ctl[i].cmd = CELL_FROM_HEAD;
            end
          end
          if (read_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.success = out_success_r;
  assign out_ch.value   = out_value_r;
  assign out_ch.count   = out_count_r;
  assign out_ch.last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count beyond capacity");

  a_keys_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> $onehot0(hit))
    else $error("key held in more than one cell");

  a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> idx_r < count_r)
    else $error("read index past stored count");

  a_read_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("read stream ended without a last beat");

endmodule
